// ===== rtl/alr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alr_pkg
// Shared types and constants of the stereo loop recorder: sample format,
// looper modes, command codes and the fixed-point constants of the mixer.
// ----------------------------------------------------------------------------
package alr_pkg;

    // Sample format
    localparam int SAMPLE_BITS = 16;
    localparam int FRAME_BITS  = 2 * SAMPLE_BITS;
    localparam int STAT_BITS   = 17;
    localparam int LEVEL_BITS  = 7;
    localparam int OP_BITS     = 3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    localparam t_sample SAMPLE_MAX = t_sample'((64'(1) << (SAMPLE_BITS - 1)) - 64'(1));
    localparam t_sample SAMPLE_MIN = t_sample'(64'(1) << (SAMPLE_BITS - 1));

    // Level in percent; full scale
    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = LEVEL_BITS'(100);

    // Mix sum: live*100 + stored*level, magnitude at most 100 * 2^SAMPLE_BITS
    localparam int SUM_W   = SAMPLE_BITS + 8;
    localparam int MAG_W   = SAMPLE_BITS + 7;
    // Divide by 100 through a rounded-up reciprocal, exact for MAG_W-bit values
    localparam int RECIP_SHIFT = MAG_W + 7;
    localparam int RECIP_W     = MAG_W + 1;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int QUOT_W      = SAMPLE_BITS + 1;
    localparam longint unsigned RECIP_VAL =
        ((longint'(1) << RECIP_SHIFT) + longint'(99)) / longint'(100);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam logic signed [SUM_W-1:0] LIVE_GAIN = SUM_W'(100);
    localparam logic [QUOT_W-1:0] QUOT_POS_LIM = QUOT_W'((64'(1) << (SAMPLE_BITS - 1)) - 64'(1));
    localparam logic [QUOT_W-1:0] QUOT_NEG_LIM = QUOT_W'(64'(1) << (SAMPLE_BITS - 1));

    // Looper modes
    typedef enum logic [2:0] {
        MODE_EMPTY     = 3'd0,
        MODE_RECORDING = 3'd1,
        MODE_PLAYING   = 3'd2,
        MODE_OVERDUB   = 3'd3,
        MODE_STOPPED   = 3'd4
    } t_mode;

    // Command codes
    localparam logic [OP_BITS-1:0] OP_NONE   = 3'd0;
    localparam logic [OP_BITS-1:0] OP_RECORD = 3'd1;
    localparam logic [OP_BITS-1:0] OP_STOP   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_PLAY   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd4;

    // Status that travels with each frame down the mixer pipeline
    typedef struct packed {
        t_mode                 mode;
        logic [STAT_BITS-1:0]  len;
        logic [STAT_BITS-1:0]  pos;
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/alr_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alr_store
// Loop sample store: one write port, one synchronous registered read port,
// and bypass of a write that lands on the entry being read in the same cycle.
// ----------------------------------------------------------------------------
module alr_store #(
    parameter int DEPTH = 65536
) (
    input  wire                                i_clk,
    input  wire                                i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0]           i_rd_addr,
    input  wire                                i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0]           i_wr_addr,
    input  wire  [alr_pkg::FRAME_BITS-1:0]     i_wr_data,
    output logic [alr_pkg::FRAME_BITS-1:0]     o_rd_data
);

    logic [alr_pkg::FRAME_BITS-1:0] r_mem [0:DEPTH-1];
    logic [alr_pkg::FRAME_BITS-1:0] r_q;
    logic [alr_pkg::FRAME_BITS-1:0] r_fwd_data;
    logic                           r_fwd_hit;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    // Capture a write to the same entry in the read cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_q;

endmodule
`default_nettype wire

// ===== rtl/audio_loop_recorder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_loop_recorder
// Stereo loop recorder with overdub. One command and one stereo frame go in,
// one mixed frame and the looper status come out.
//
// Input stream: each transfer carries a command (none, record, stop, play,
// clear) and a live stereo frame. The command is applied first, then the frame
// is recorded, passed through, or mixed with the loop as
// sat((live*100 + stored*level) / 100), truncated toward zero. In overdub the
// saturated sum of stored and live is written back to the loop store.
// Output stream: one transfer per input transfer, in order, with the mode,
// loop length and current position after that frame.
// Config channel: writes the playback level in percent; values above 100
// act as 100. Write only while no frames are in flight.
// Throughput: one frame per cycle while the output is not stalled. Stages:
// store read, mix sum, reciprocal multiply, then the saturating output
// register. The store is read as a frame is accepted; the overdub write-back
// comes as it leaves the read stage. A bypass covers a loop of one frame.
// Reset: empty mode, zero length and positions, level 100; the store is not
// cleared. A stalled output holds its frame; the pipeline keeps accepting
// until all stages are full, then deasserts s_axis_tready.
// ----------------------------------------------------------------------------
module audio_loop_recorder #(
    parameter int MAX_FRAMES = 65536
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // opcode[2:0], left_in[18:3], right_in[34:19]
    // Output stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [71:0] m_axis_tdata,   // left_out[15:0], right_out[31:16], mode[34:32],
                                        // length_now[51:35], position_now[68:52]
    // Config channel
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [6:0]  i_cfg_data      // playback_level
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_FRAMES);

    // ------------------------------------------------------------------------
    // Input unpack
    // ------------------------------------------------------------------------
    logic [alr_pkg::OP_BITS-1:0] w_op;
    alr_pkg::t_sample            w_in_l;
    alr_pkg::t_sample            w_in_r;

    assign w_op   = s_axis_tdata[2:0];
    assign w_in_l = alr_pkg::t_sample'(s_axis_tdata[18:3]);
    assign w_in_r = alr_pkg::t_sample'(s_axis_tdata[34:19]);

    // ------------------------------------------------------------------------
    // Control state and pipeline registers
    // ------------------------------------------------------------------------
    alr_pkg::t_mode              r_mode, n_mode;
    logic [CW-1:0]               r_len, n_len;
    logic [CW-1:0]               r_rec, n_rec;
    logic [AW-1:0]               r_play, n_play;
    logic [alr_pkg::LEVEL_BITS-1:0] r_level;

    logic                        r_v1, r_v2, r_v3, r_ov;
    alr_pkg::t_sample            r_s1_l, r_s1_r;
    logic                        r_s1_play;
    logic                        r_s1_ovd;
    logic [AW-1:0]               r_s1_addr;
    alr_pkg::t_status            r_s1_stat;

    logic signed [alr_pkg::SUM_W-1:0] r_s2_sum_l, r_s2_sum_r;
    alr_pkg::t_status            r_s2_stat;

    logic [alr_pkg::QUOT_W-1:0]  r_s3_q_l, r_s3_q_r;
    logic                        r_s3_neg_l, r_s3_neg_r;
    alr_pkg::t_status            r_s3_stat;

    alr_pkg::t_sample            r_o_l, r_o_r;
    alr_pkg::t_status            r_o_stat;

    // Handshake and stage movement
    logic w_accept, w_move1, w_move2, w_move3, w_move_out;

    assign w_move_out    = r_v3 && (!r_ov || m_axis_tready);
    assign w_move3       = w_move_out;
    assign w_move2       = r_v2 && (!r_v3 || w_move3);
    assign w_move1       = r_v1 && (!r_v2 || w_move2);
    assign s_axis_tready = !r_v1 || w_move1;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // ------------------------------------------------------------------------
    // Command and position update
    // ------------------------------------------------------------------------
    alr_pkg::t_mode   c_mode;
    logic [CW-1:0]    c_len;
    logic [CW-1:0]    c_rec;
    logic [AW-1:0]    c_play;
    logic [CW-1:0]    c_inc;
    logic             c_rec_we;
    logic [AW-1:0]    c_rec_addr;
    logic             c_play_item;
    logic [AW-1:0]    c_rd_addr;
    alr_pkg::t_status c_stat;

    always_comb begin
        c_mode      = r_mode;
        c_len       = r_len;
        c_rec       = r_rec;
        c_play      = r_play;
        c_rec_we    = 1'b0;
        c_rec_addr  = '0;
        c_play_item = 1'b0;
        c_rd_addr   = '0;
        c_inc       = '0;

        // Apply the command
        unique case (w_op)
            alr_pkg::OP_RECORD: begin
                unique case (r_mode)
                    alr_pkg::MODE_EMPTY, alr_pkg::MODE_STOPPED: begin
                        if (r_mode == alr_pkg::MODE_STOPPED && r_len != '0) begin
                            c_mode = alr_pkg::MODE_PLAYING;
                        end else begin
                            c_mode = alr_pkg::MODE_RECORDING;
                            c_rec  = '0;
                            c_len  = '0;
                        end
                    end
                    alr_pkg::MODE_RECORDING: begin
                        c_len = r_rec;
                        if (r_rec != '0) begin
                            c_mode = alr_pkg::MODE_PLAYING;
                            c_play = '0;
                        end else begin
                            c_mode = alr_pkg::MODE_EMPTY;
                        end
                    end
                    alr_pkg::MODE_PLAYING: c_mode = alr_pkg::MODE_OVERDUB;
                    alr_pkg::MODE_OVERDUB: c_mode = alr_pkg::MODE_PLAYING;
                    default: ;
                endcase
            end
            alr_pkg::OP_STOP: begin
                if (r_mode == alr_pkg::MODE_RECORDING) begin
                    c_len  = r_rec;
                    c_mode = (r_rec != '0) ? alr_pkg::MODE_STOPPED : alr_pkg::MODE_EMPTY;
                end else if (r_mode == alr_pkg::MODE_PLAYING ||
                             r_mode == alr_pkg::MODE_OVERDUB) begin
                    c_mode = alr_pkg::MODE_STOPPED;
                end
            end
            alr_pkg::OP_PLAY: begin
                if (r_len != '0) begin
                    c_mode = alr_pkg::MODE_PLAYING;
                end
            end
            alr_pkg::OP_CLEAR: begin
                c_mode = alr_pkg::MODE_EMPTY;
                c_len  = '0;
                c_rec  = '0;
                c_play = '0;
            end
            default: ;
        endcase

        // Record the frame, or close the loop when the store is full
        if (c_mode == alr_pkg::MODE_RECORDING) begin
            if (c_rec < MAX_COUNT) begin
                c_rec_we   = 1'b1;
                c_rec_addr = c_rec[AW-1:0];
                c_rec      = c_rec + CW'(1);
            end else begin
                c_len  = c_rec;
                c_mode = (c_rec != '0) ? alr_pkg::MODE_PLAYING : alr_pkg::MODE_EMPTY;
                c_play = '0;
            end
        end

        // Play from the loop and advance with wrap
        if (!c_rec_we && (c_mode == alr_pkg::MODE_PLAYING ||
                          c_mode == alr_pkg::MODE_OVERDUB) && c_len != '0) begin
            c_play_item = 1'b1;
            c_rd_addr   = c_play;
            c_inc       = CW'(c_play) + CW'(1);
            c_play      = (c_inc >= c_len) ? '0 : c_inc[AW-1:0];
        end

        c_stat.mode = c_mode;
        c_stat.len  = alr_pkg::STAT_BITS'(c_len);
        c_stat.pos  = (c_mode == alr_pkg::MODE_RECORDING) ?
                      alr_pkg::STAT_BITS'(c_rec) : alr_pkg::STAT_BITS'(c_play);

        n_mode = w_accept ? c_mode : r_mode;
        n_len  = w_accept ? c_len  : r_len;
        n_rec  = w_accept ? c_rec  : r_rec;
        n_play = w_accept ? c_play : r_play;
    end

    // Hold the looper state and the level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= alr_pkg::MODE_EMPTY;
            r_len   <= '0;
            r_rec   <= '0;
            r_play  <= '0;
            r_level <= alr_pkg::LEVEL_FULL;
        end else begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_rec  <= n_rec;
            r_play <= n_play;
            if (i_cfg_valid) begin
                r_level <= (i_cfg_data > alr_pkg::LEVEL_FULL) ? alr_pkg::LEVEL_FULL
                                                               : i_cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Loop store
    // ------------------------------------------------------------------------
    logic [alr_pkg::FRAME_BITS-1:0] w_rd_data;
    alr_pkg::t_sample               w_st_l, w_st_r;
    logic                           w_ovd_we;
    logic                           w_wr_en;
    logic [AW-1:0]                  w_wr_addr;
    logic [alr_pkg::FRAME_BITS-1:0] w_wr_data;
    alr_pkg::t_sample               w_wb_l, w_wb_r;

    function automatic alr_pkg::t_sample sat_add(alr_pkg::t_sample a, alr_pkg::t_sample b);
        logic signed [alr_pkg::SAMPLE_BITS:0] s;
        s = (alr_pkg::SAMPLE_BITS + 1)'(a) + (alr_pkg::SAMPLE_BITS + 1)'(b);
        if (s[alr_pkg::SAMPLE_BITS] != s[alr_pkg::SAMPLE_BITS-1]) begin
            return s[alr_pkg::SAMPLE_BITS] ? alr_pkg::SAMPLE_MIN : alr_pkg::SAMPLE_MAX;
        end
        return alr_pkg::t_sample'(s[alr_pkg::SAMPLE_BITS-1:0]);
    endfunction

    assign w_st_l = alr_pkg::t_sample'(w_rd_data[alr_pkg::SAMPLE_BITS-1:0]);
    assign w_st_r = alr_pkg::t_sample'(w_rd_data[alr_pkg::FRAME_BITS-1:alr_pkg::SAMPLE_BITS]);

    // Overdub write-back as the frame leaves the read stage
    assign w_wb_l    = sat_add(w_st_l, r_s1_l);
    assign w_wb_r    = sat_add(w_st_r, r_s1_r);
    assign w_ovd_we  = w_move1 && r_s1_ovd;
    assign w_wr_en   = (w_accept && c_rec_we) || w_ovd_we;
    assign w_wr_addr = w_ovd_we ? r_s1_addr : c_rec_addr;
    assign w_wr_data = w_ovd_we ? {w_wb_r, w_wb_l} : {w_in_r, w_in_l};

    alr_store #(
        .DEPTH (MAX_FRAMES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept && c_play_item),
        .i_rd_addr (c_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    // ------------------------------------------------------------------------
    // Mixer pipeline
    // ------------------------------------------------------------------------
    logic signed [alr_pkg::SUM_W-1:0] w_live_l, w_live_r, w_stx_l, w_stx_r, w_lvl;
    logic signed [alr_pkg::SUM_W-1:0] w_sum_l, w_sum_r;
    logic [alr_pkg::MAG_W-1:0]        w_mag_l, w_mag_r;
    logic [alr_pkg::PROD_W-1:0]       w_prod_l, w_prod_r;
    alr_pkg::t_sample                 w_res_l, w_res_r;

    function automatic alr_pkg::t_sample sat_quot(logic [alr_pkg::QUOT_W-1:0] q,
                                                  logic neg);
        logic [alr_pkg::QUOT_W-1:0] nq;
        nq = ~q + alr_pkg::QUOT_W'(1);
        if (!neg) begin
            return (q > alr_pkg::QUOT_POS_LIM) ? alr_pkg::SAMPLE_MAX
                                               : alr_pkg::t_sample'(q[alr_pkg::SAMPLE_BITS-1:0]);
        end
        return (q > alr_pkg::QUOT_NEG_LIM) ? alr_pkg::SAMPLE_MIN
                                           : alr_pkg::t_sample'(nq[alr_pkg::SAMPLE_BITS-1:0]);
    endfunction

    // Sum of live and scaled loop; pass-through frames carry live*100
    assign w_live_l = alr_pkg::SUM_W'(r_s1_l);
    assign w_live_r = alr_pkg::SUM_W'(r_s1_r);
    assign w_stx_l  = alr_pkg::SUM_W'(w_st_l);
    assign w_stx_r  = alr_pkg::SUM_W'(w_st_r);
    assign w_lvl    = alr_pkg::SUM_W'($signed({1'b0, r_level}));
    assign w_sum_l  = w_live_l * alr_pkg::LIVE_GAIN + (r_s1_play ? w_stx_l * w_lvl : '0);
    assign w_sum_r  = w_live_r * alr_pkg::LIVE_GAIN + (r_s1_play ? w_stx_r * w_lvl : '0);

    // Magnitude times reciprocal of 100
    assign w_mag_l  = r_s2_sum_l[alr_pkg::SUM_W-1] ? alr_pkg::MAG_W'(-r_s2_sum_l)
                                                   : alr_pkg::MAG_W'(r_s2_sum_l);
    assign w_mag_r  = r_s2_sum_r[alr_pkg::SUM_W-1] ? alr_pkg::MAG_W'(-r_s2_sum_r)
                                                   : alr_pkg::MAG_W'(r_s2_sum_r);
    assign w_prod_l = alr_pkg::PROD_W'(w_mag_l) * alr_pkg::PROD_W'(alr_pkg::RECIP);
    assign w_prod_r = alr_pkg::PROD_W'(w_mag_r) * alr_pkg::PROD_W'(alr_pkg::RECIP);

    // Restore sign and saturate
    assign w_res_l  = sat_quot(r_s3_q_l, r_s3_neg_l);
    assign w_res_r  = sat_quot(r_s3_q_r, r_s3_neg_r);

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_v1 <= s_axis_tvalid;
            end
            if (!r_v2 || w_move2) begin
                r_v2 <= w_move1;
            end
            if (!r_v3 || w_move3) begin
                r_v3 <= w_move2;
            end
            if (!r_ov || m_axis_tready) begin
                r_ov <= w_move_out;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_l    <= w_in_l;
            r_s1_r    <= w_in_r;
            r_s1_play <= c_play_item;
            r_s1_ovd  <= c_play_item && (c_mode == alr_pkg::MODE_OVERDUB);
            r_s1_addr <= c_rd_addr;
            r_s1_stat <= c_stat;
        end
        if (w_move1) begin
            r_s2_sum_l <= w_sum_l;
            r_s2_sum_r <= w_sum_r;
            r_s2_stat  <= r_s1_stat;
        end
        if (w_move2) begin
            r_s3_q_l   <= w_prod_l[alr_pkg::PROD_W-1:alr_pkg::RECIP_SHIFT];
            r_s3_q_r   <= w_prod_r[alr_pkg::PROD_W-1:alr_pkg::RECIP_SHIFT];
            r_s3_neg_l <= r_s2_sum_l[alr_pkg::SUM_W-1];
            r_s3_neg_r <= r_s2_sum_r[alr_pkg::SUM_W-1];
            r_s3_stat  <= r_s2_stat;
        end
        if (w_move_out) begin
            r_o_l    <= w_res_l;
            r_o_r    <= w_res_r;
            r_o_stat <= r_s3_stat;
        end
    end

    // ------------------------------------------------------------------------
    // Output pack
    // ------------------------------------------------------------------------
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {3'b000, r_o_stat.pos, r_o_stat.len, r_o_stat.mode, r_o_r, r_o_l};

endmodule
`default_nettype wire
